// ===== src/gdr_pkg.sv =====
`timescale 1ns / 1ps
package gdr_pkg;

   localparam int unsigned POS_W   = 22;
   localparam int unsigned DIR_W   = 19;
   localparam int unsigned DIST_W  = 24;
   localparam int unsigned LH_W    = 16;
   localparam int unsigned ROW_W   = 9;
   localparam int unsigned CELL_W  = 8;
   localparam int unsigned COORD_W = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 22;

   localparam logic [CELL_W-1:0] EMPTY_A = 8'h30;
   localparam logic [CELL_W-1:0] EMPTY_B = 8'h78;
   localparam logic [16:0]       ONE_Q16 = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X   = 3'd0,
      CSR_POS_Y   = 3'd1,
      CSR_DIR_X   = 3'd2,
      CSR_DIR_Y   = 3'd3,
      CSR_PLANE_X = 3'd4,
      CSR_PLANE_Y = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RAY,
      ST_DIV_DX,
      ST_DIV_DY,
      ST_SIDE,
      ST_STEP,
      ST_READ,
      ST_CHECK,
      ST_PERP,
      ST_HEIGHT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               mode;
      logic [9:0]         column;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [CELL_W-1:0]  cell_value;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] hit_x;
      logic [COORD_W-1:0] hit_y;
      logic [CELL_W-1:0]  hit_cell;
      logic               hit_side;
      logic [DIST_W-1:0]  perp_distance;
      logic [LH_W-1:0]    line_height;
      logic [ROW_W-1:0]   line_start;
      logic [ROW_W-1:0]   line_end;
      logic               ray_lost;
   } rsp_type;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

endpackage

// ===== src/gdr_ram.sv =====
`timescale 1ns / 1ps
module gdr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== src/gdr_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module gdr_div (
   input  logic                     clock,
   input  logic                     reset,
   input  gdr_pkg::div_req_type     div_req,
   output logic                     busy,
   output logic [63:0]              quot
);
   import gdr_pkg::*;

   logic [63:0] rem_ff, rem_in, q_ff, q_in, den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] trial;

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, q_ff[63]} - {1'b0, den_ff};
      if (div_req.start) begin
         rem_in = '0;
         q_in   = div_req.num;
         den_in = div_req.den;
         cnt_in = 7'd64;
      end else if (cnt_ff != '0) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], q_ff[63]};
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign busy = div_req.start || (cnt_ff != '0);
   assign quot = q_ff;

`ifndef SYNTHESIS
   a_cnt_load: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> cnt_ff == 7'd64)
      else $error("divider did not load");
   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      (!div_req.start && cnt_ff != '0) |=> cnt_ff == $past(cnt_ff) - 7'd1)
      else $error("divider count skipped");
   a_cnt_rng: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 7'd64)
      else $error("divider count out of range");
`endif
endmodule

// ===== src/gdr_core.sv =====
`timescale 1ns / 1ps
// Sequencer: map clear and writes, ray setup, DDA walk over the map memory, distance and height.
module gdr_core #(
   parameter int unsigned MAP_SIDE      = 64,
   parameter int unsigned SCREEN_WIDTH  = 640,
   parameter int unsigned SCREEN_HEIGHT = 480,
   parameter int unsigned MAX_STEPS     = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  gdr_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output gdr_pkg::rsp_type             rsp_data,
   input  logic [gdr_pkg::POS_W-1:0]    pos_x,
   input  logic [gdr_pkg::POS_W-1:0]    pos_y,
   input  logic signed [gdr_pkg::DIR_W-1:0] dir_x,
   input  logic signed [gdr_pkg::DIR_W-1:0] dir_y,
   input  logic signed [gdr_pkg::DIR_W-1:0] pln_x,
   input  logic signed [gdr_pkg::DIR_W-1:0] pln_y
);
   import gdr_pkg::*;

   localparam int unsigned CW      = $clog2(MAP_SIDE);
   localparam int unsigned AW      = 2 * CW;
   localparam int unsigned DEPTH   = 1 << AW;
   localparam int unsigned SW      = $clog2(MAX_STEPS + 1);
   // Side distances grow by at most one saturated delta per step.
   localparam int unsigned SXW     = 34 + SW;
   localparam int unsigned HALF    = SCREEN_HEIGHT / 2;
   localparam int unsigned HMAX    = SCREEN_HEIGHT - 1;
   localparam longint unsigned HNUM = longint'(SCREEN_HEIGHT) << 16;
   // Rounded-up reciprocal of the screen width; exact for every 10-bit column.
   localparam longint unsigned CAM_RECIP =
      ((longint'(1) << 39) + longint'(SCREEN_WIDTH) - 1) / longint'(SCREEN_WIDTH);

   state_type state_ff, state_in;

   logic [AW:0]       clr_ff, clr_in;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic              wr_en;
   logic [CELL_W-1:0] wr_data, rd_data;

   logic signed [19:0] cam_ff, cam_in;
   logic signed [19:0] rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [31:0]        dlx_ff, dlx_in, dly_ff, dly_in;
   logic [SXW-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic signed [9:0]  mx_ff, mx_in, my_ff, my_in;
   logic [SW-1:0]      n_ff, n_in;
   logic               side_ff, side_in;
   logic [1:0]         phase_ff, phase_in;
   logic [DIST_W-1:0]  perp_ff, perp_in;
   rsp_type            out_ff, out_in;
   rsp_type            rsp_ff, rsp_in;
   logic               vld_ff, vld_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;

   div_req_type dreq;
   logic        dbusy;
   logic [63:0] dquot;

   logic signed [39:0] prod;
   logic [45:0]        cam_prod;
   logic [19:0]        mag_r;
   logic [16:0]        frac;
   logic [49:0]        sprod;
   logic signed [27:0] num;
   logic [27:0]        num_mag;
   logic [15:0]        lh;
   logic               outside;

   gdr_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   gdr_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(dreq),
      .busy   (dbusy),
      .quot   (dquot)
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cam_in   = cam_ff;
      rdx_in   = rdx_ff;
      rdy_in   = rdy_ff;
      dlx_in   = dlx_ff;
      dly_in   = dly_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      n_in     = n_ff;
      side_in  = side_ff;
      phase_in = phase_ff;
      perp_in  = perp_ff;
      out_in   = out_ff;
      rsp_in   = rsp_ff;
      vld_in   = vld_ff;
      cell_in  = cell_ff;
      wr_en    = 1'b0;
      wr_addr  = clr_ff[AW-1:0];
      wr_data  = EMPTY_A;
      rd_addr  = {my_ff[CW-1:0], mx_ff[CW-1:0]};
      dreq     = '0;
      req_stall = 1'b1;
      prod     = '0;
      cam_prod = '0;
      mag_r    = '0;
      frac     = '0;
      sprod    = '0;
      num      = '0;
      num_mag  = '0;
      lh       = '0;
      outside  = 1'b0;

      if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!req_data.mode) begin
                  wr_en   = (32'(req_data.cell_x) < MAP_SIDE) &&
                            (32'(req_data.cell_y) < MAP_SIDE);
                  wr_addr = {CW'(req_data.cell_y), CW'(req_data.cell_x)};
                  wr_data = req_data.cell_value;
               end else begin
                  cam_prod = 46'(req_data.column) * 46'(CAM_RECIP);
                  cam_in = signed'(20'(cam_prod[45:22])) - 20'sd65536;
                  phase_in = '0;
                  state_in = ST_RAY;
               end
            end
         end
         ST_RAY: begin
            // One multiply per cycle: x component, then y component.
            prod = (phase_ff == 2'd0 ? 40'(pln_x) : 40'(pln_y)) * 40'(cam_ff);
            if (phase_ff == 2'd0) begin
               rdx_in = 20'(dir_x) + 20'(prod >>> 16);
               phase_in = 2'd1;
            end else begin
               rdy_in = 20'(dir_y) + 20'(prod >>> 16);
               phase_in = '0;
               state_in = ST_DIV_DX;
            end
         end
         ST_DIV_DX, ST_DIV_DY: begin
            mag_r = (state_ff == ST_DIV_DX) ?
                    (rdx_ff[19] ? 20'(-rdx_ff) : rdx_ff) :
                    (rdy_ff[19] ? 20'(-rdy_ff) : rdy_ff);
            if (phase_ff == 2'd0) begin
               if (mag_r == '0) begin
                  if (state_ff == ST_DIV_DX) dlx_in = '1;
                  else dly_in = '1;
                  state_in = (state_ff == ST_DIV_DX) ? ST_DIV_DY : ST_SIDE;
               end else begin
                  dreq.start = 1'b1;
                  dreq.num   = 64'h1_0000_0000;
                  dreq.den   = 64'(mag_r);
                  phase_in   = 2'd1;
               end
            end else if (!dbusy) begin
               if (state_ff == ST_DIV_DX) begin
                  dlx_in = (dquot[63:32] != '0) ? '1 : dquot[31:0];
                  state_in = ST_DIV_DY;
               end else begin
                  dly_in = (dquot[63:32] != '0) ? '1 : dquot[31:0];
                  state_in = ST_SIDE;
               end
               phase_in = '0;
            end
         end
         ST_SIDE: begin
            if (phase_ff == 2'd0) begin
               frac  = rdx_ff[19] ? {1'b0, pos_x[15:0]} : ONE_Q16 - {1'b0, pos_x[15:0]};
               sprod = 50'(frac) * 50'(dlx_ff);
               sx_in = SXW'(sprod >> 16);
               mx_in = 10'(pos_x[POS_W-1:16]);
               phase_in = 2'd1;
            end else begin
               frac  = rdy_ff[19] ? {1'b0, pos_y[15:0]} : ONE_Q16 - {1'b0, pos_y[15:0]};
               sprod = 50'(frac) * 50'(dly_ff);
               sy_in = SXW'(sprod >> 16);
               my_in = 10'(pos_y[POS_W-1:16]);
               phase_in = '0;
               n_in  = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (n_ff == SW'(MAX_STEPS)) begin
               state_in = ST_DONE;
               out_in   = '0;
               out_in.ray_lost = 1'b1;
               out_in.perp_distance = '1;
               out_in.line_start = ROW_W'(HALF > HMAX ? HMAX : HALF);
               out_in.line_end   = ROW_W'(HALF > HMAX ? HMAX : HALF);
            end else begin
               if (sx_ff < sy_ff) begin
                  sx_in = sx_ff + SXW'(dlx_ff);
                  mx_in = rdx_ff[19] ? mx_ff - 10'sd1 : mx_ff + 10'sd1;
                  side_in = 1'b0;
               end else begin
                  sy_in = sy_ff + SXW'(dly_ff);
                  my_in = rdy_ff[19] ? my_ff - 10'sd1 : my_ff + 10'sd1;
                  side_in = 1'b1;
               end
               n_in = n_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            outside = mx_ff < 0 || my_ff < 0 || mx_ff >= 10'(MAP_SIDE) ||
                      my_ff >= 10'(MAP_SIDE);
            if (outside) begin
               state_in = ST_DONE;
               out_in   = '0;
               out_in.ray_lost = 1'b1;
               out_in.perp_distance = '1;
               out_in.line_start = ROW_W'(HALF > HMAX ? HMAX : HALF);
               out_in.line_end   = ROW_W'(HALF > HMAX ? HMAX : HALF);
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rd_data != EMPTY_A && rd_data != EMPTY_B) begin
               cell_in  = rd_data;
               phase_in = '0;
               state_in = ST_PERP;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_PERP: begin
            mag_r = side_ff ? (rdy_ff[19] ? 20'(-rdy_ff) : rdy_ff) :
                              (rdx_ff[19] ? 20'(-rdx_ff) : rdx_ff);
            num = side_ff ?
               (28'(my_ff) <<< 16) - 28'(pos_y) + (rdy_ff[19] ? 28'sd65536 : 28'sd0) :
               (28'(mx_ff) <<< 16) - 28'(pos_x) + (rdx_ff[19] ? 28'sd65536 : 28'sd0);
            num_mag = num[27] ? 28'(-num) : num;
            if (phase_ff == 2'd0) begin
               if (mag_r == '0) begin
                  perp_in = '1;
                  state_in = ST_HEIGHT;
               end else begin
                  dreq.start = 1'b1;
                  dreq.num   = 64'(num_mag) << 16;
                  dreq.den   = 64'(mag_r);
                  phase_in   = 2'd1;
               end
            end else if (!dbusy) begin
               perp_in  = (dquot[63:DIST_W] != '0) ? '1 : dquot[DIST_W-1:0];
               phase_in = '0;
               state_in = ST_HEIGHT;
            end
         end
         ST_HEIGHT: begin
            if (phase_ff == 2'd0) begin
               if (perp_ff == '0) begin
                  phase_in = 2'd2;
               end else begin
                  dreq.start = 1'b1;
                  dreq.num   = 64'(HNUM);
                  dreq.den   = 64'(perp_ff);
                  phase_in   = 2'd1;
               end
            end else if (phase_ff == 2'd2 || !dbusy) begin
               if (phase_ff == 2'd2) lh = '1;
               else lh = (dquot[63:16] != '0) ? '1 : dquot[15:0];
               out_in.hit_x    = COORD_W'(mx_ff);
               out_in.hit_y    = COORD_W'(my_ff);
               out_in.hit_cell = cell_ff;
               out_in.hit_side = side_ff;
               out_in.perp_distance = perp_ff;
               out_in.line_height   = lh;
               out_in.ray_lost = 1'b0;
               out_in.line_start = (32'(lh >> 1) > HALF) ? '0 :
                                   ROW_W'(HALF - 32'(lh >> 1));
               out_in.line_end   = (HALF + 32'(lh >> 1) >= SCREEN_HEIGHT) ?
                                   ROW_W'(HMAX) : ROW_W'(HALF + 32'(lh >> 1));
               phase_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The result register is loaded only once the previous result is gone.
            if (!vld_ff || !rsp_stall) begin
               vld_in = 1'b1;
               rsp_in = out_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         vld_ff   <= 1'b0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         vld_ff   <= vld_in;
         phase_ff <= phase_in;
      end
      cam_ff  <= cam_in;
      rdx_ff  <= rdx_in;
      rdy_ff  <= rdy_in;
      dlx_ff  <= dlx_in;
      dly_ff  <= dly_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      n_ff    <= n_in;
      side_ff <= side_in;
      perp_ff <= perp_in;
      out_ff  <= out_in;
      rsp_ff  <= rsp_in;
      cell_ff <= cell_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_acc_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("transaction accepted during map clear");
   a_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> n_ff <= SW'(MAX_STEPS))
      else $error("step counter overran");
   a_lost_fmt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ray_lost) |-> rsp_data.line_height == '0)
      else $error("lost ray with nonzero height");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
`endif
endmodule

// ===== src/grid_dda_ray_caster.sv =====
`timescale 1ns / 1ps
// Grid DDA ray caster. A map-write transaction is written in the cycle it is
// accepted. A cast sets up the ray with two multiplies, runs two reciprocals on
// a shared bit-serial divider, walks the map with one memory read per step
// (ST_STEP, ST_READ and ST_CHECK, up to MAX_STEPS steps), then spends two more
// divisions on distance and height; each division holds the sequencer until
// the divider is done. After reset a clearing pass, one map entry per cycle
// (4096 entries with the default map), fills the map with '0'; no
// transaction is accepted during it, configuration writes are.
module grid_dda_ray_caster #(
   parameter int unsigned MAP_SIDE      = 64,
   parameter int unsigned SCREEN_WIDTH  = 640,
   parameter int unsigned SCREEN_HEIGHT = 480,
   parameter int unsigned MAX_STEPS     = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gdr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gdr_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gdr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gdr_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import gdr_pkg::*;

   logic [POS_W-1:0]        pos_x_ff, pos_y_ff;
   logic signed [DIR_W-1:0] dir_x_ff, dir_y_ff, pln_x_ff, pln_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= 22'd2162688;
         pos_y_ff <= 22'd2162688;
         dir_x_ff <= -19'sd65536;
         dir_y_ff <= '0;
         pln_x_ff <= '0;
         pln_y_ff <= 19'sd43253;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_POS_X:   pos_x_ff <= csr_wdata;
            CSR_POS_Y:   pos_y_ff <= csr_wdata;
            CSR_DIR_X:   dir_x_ff <= csr_wdata[DIR_W-1:0];
            CSR_DIR_Y:   dir_y_ff <= csr_wdata[DIR_W-1:0];
            CSR_PLANE_X: pln_x_ff <= csr_wdata[DIR_W-1:0];
            CSR_PLANE_Y: pln_y_ff <= csr_wdata[DIR_W-1:0];
            default: ;
         endcase
      end
   end

   gdr_core #(
      .MAP_SIDE     (MAP_SIDE),
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .MAX_STEPS    (MAX_STEPS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .pos_x    (pos_x_ff),
      .pos_y    (pos_y_ff),
      .dir_x    (dir_x_ff),
      .dir_y    (dir_y_ff),
      .pln_x    (pln_x_ff),
      .pln_y    (pln_y_ff)
   );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import gdr_pkg::*;

   localparam int unsigned MAP_SIDE      = 64;
   localparam int unsigned SCREEN_WIDTH  = 640;
   localparam int unsigned SCREEN_HEIGHT = 480;
   localparam int unsigned MAX_STEPS     = 128;
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CAST  = 1'b1;
   localparam longint DELTA_SAT  = 64'hFFFF_FFFF;
   localparam longint PERP_SAT   = 64'hFF_FFFF;
   localparam longint HEIGHT_SAT = 64'hFFFF;
   localparam int DRAIN_CYCLES = 1000;
   localparam longint CYCLE_LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   req_type pending_reqs[$];
   rsp_type expected_hits[$];
   logic [7:0] map_mirror[MAP_SIDE*MAP_SIDE];
   longint cam_x, cam_y, dir_x, dir_y, pln_x, pln_y;
   int failures = 0;
   int n_writes = 0, n_casts = 0, n_lost = 0, n_checked = 0;
   longint cycles = 0;
   bit quiet = 1'b0;
   int send_gap = 0, recv_gap = 0;

   grid_dda_ray_caster u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic longint sext19(longint v);
      longint m;
      m = v & 64'h7FFFF;
      if (m & 64'h40000) m -= 64'h80000;
      return m;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint reciprocal(longint d);
      longint m;
      m = magnitude(d);
      if (m == 0) return DELTA_SAT;
      return ((64'd1 << 32) / m > DELTA_SAT) ? DELTA_SAT : (64'd1 << 32) / m;
   endfunction

   function automatic rsp_type cast_column(logic [9:0] column);
      longint cam, rdx, rdy, dlx, dly, sx, sy, mx, my, stx, sty;
      longint num, den, perp, lh, half;
      int side, steps;
      bit hit;
      logic [7:0] hit_val;
      rsp_type r;
      half = SCREEN_HEIGHT / 2;
      side = 0;
      hit = 0;
      hit_val = 0;
      r = '0;
      cam = (longint'(column) * 2 * 65536) / SCREEN_WIDTH - 65536;
      rdx = dir_x + ((pln_x * cam) >>> 16);
      rdy = dir_y + ((pln_y * cam) >>> 16);
      dlx = reciprocal(rdx);
      dly = reciprocal(rdy);
      mx = cam_x >> 16;
      my = cam_y >> 16;
      if (rdx < 0) begin
         stx = -1; sx = ((cam_x & 16'hFFFF) * dlx) >> 16;
      end else begin
         stx = 1; sx = ((65536 - (cam_x & 16'hFFFF)) * dlx) >> 16;
      end
      if (rdy < 0) begin
         sty = -1; sy = ((cam_y & 16'hFFFF) * dly) >> 16;
      end else begin
         sty = 1; sy = ((65536 - (cam_y & 16'hFFFF)) * dly) >> 16;
      end
      for (steps = 0; steps < MAX_STEPS; steps++) begin
         if (sx < sy) begin
            sx += dlx; mx += stx; side = 0;
         end else begin
            sy += dly; my += sty; side = 1;
         end
         if (mx < 0 || my < 0 || mx >= MAP_SIDE || my >= MAP_SIDE) break;
         hit_val = map_mirror[my * MAP_SIDE + mx];
         if (hit_val != EMPTY_A && hit_val != EMPTY_B) begin
            hit = 1;
            break;
         end
      end
      if (!hit) begin
         r.perp_distance = DIST_W'(PERP_SAT);
         r.line_start = ROW_W'(half);
         r.line_end = (half >= SCREEN_HEIGHT) ? ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(half);
         r.ray_lost = 1'b1;
         return r;
      end
      if (side == 0) begin
         num = mx * 65536 - cam_x + ((stx < 0) ? 65536 : 0);
         den = magnitude(rdx);
      end else begin
         num = my * 65536 - cam_y + ((sty < 0) ? 65536 : 0);
         den = magnitude(rdy);
      end
      if (den == 0) perp = PERP_SAT;
      else begin
         perp = (magnitude(num) << 16) / den;
         if (perp > PERP_SAT) perp = PERP_SAT;
      end
      if (perp == 0) lh = HEIGHT_SAT;
      else begin
         lh = (longint'(SCREEN_HEIGHT) << 16) / perp;
         if (lh > HEIGHT_SAT) lh = HEIGHT_SAT;
      end
      r.hit_x = COORD_W'(mx);
      r.hit_y = COORD_W'(my);
      r.hit_cell = hit_val;
      r.hit_side = 1'(side);
      r.perp_distance = DIST_W'(perp);
      r.line_height = LH_W'(lh);
      r.line_start = (lh / 2 > half) ? ROW_W'(0) : ROW_W'(half - lh / 2);
      r.line_end = (half + lh / 2 >= SCREEN_HEIGHT) ? ROW_W'(SCREEN_HEIGHT - 1) :
                   ROW_W'(half + lh / 2);
      return r;
   endfunction

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Driver: presents the oldest pending item; on acceptance updates the map mirror or queues the expected result.
   always @(posedge clock) begin
      req_type nxt;
      logic vld;
      vld = req_valid;
      nxt = req_data;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_data.mode == MODE_CAST) begin
               expected_hits.push_back(cast_column(req_data.column));
               n_casts++;
            end else begin
               map_mirror[req_data.cell_y * MAP_SIDE + req_data.cell_x] = req_data.cell_value;
               n_writes++;
            end
            void'(pending_reqs.pop_front());
            vld = 1'b0;
         end
         if (!vld) begin
            if (send_gap > 0) send_gap--;
            else if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(0, 7);
            else if (pending_reqs.size() > 0) begin
               vld = 1'b1;
               nxt = pending_reqs[0];
            end
         end
      end
      req_valid <= vld;
      req_data <= nxt;
   end

   function automatic bit field_ok(string name, longint exp_v, longint act_v);
      if (exp_v == act_v) return 1'b1;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      return 1'b0;
   endfunction

   // Monitor: checks each result transaction against the oldest expectation and drives random stalls.
   always @(posedge clock) begin
      rsp_type e;
      bit ok;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               $error("result transaction with nothing expected");
               failures++;
            end else begin
               e = expected_hits.pop_front();
               ok = field_ok("hit_x", 64'(e.hit_x), 64'(rsp_data.hit_x));
               ok &= field_ok("hit_y", 64'(e.hit_y), 64'(rsp_data.hit_y));
               ok &= field_ok("hit_cell", 64'(e.hit_cell), 64'(rsp_data.hit_cell));
               ok &= field_ok("hit_side", 64'(e.hit_side), 64'(rsp_data.hit_side));
               ok &= field_ok("perp_distance", 64'(e.perp_distance),
                              64'(rsp_data.perp_distance));
               ok &= field_ok("line_height", 64'(e.line_height),
                              64'(rsp_data.line_height));
               ok &= field_ok("line_start", 64'(e.line_start), 64'(rsp_data.line_start));
               ok &= field_ok("line_end", 64'(e.line_end), 64'(rsp_data.line_end));
               ok &= field_ok("ray_lost", 64'(e.ray_lost), 64'(rsp_data.ray_lost));
               if (!ok) failures++;
               if (e.ray_lost) n_lost++;
               n_checked++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Must be entered right after a rising edge; leaves csr_valid high.
   task automatic write_reg(csr_idx_type idx, longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DAT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POS_X:   cam_x = value & 64'h3FFFFF;
         CSR_POS_Y:   cam_y = value & 64'h3FFFFF;
         CSR_DIR_X:   dir_x = sext19(value);
         CSR_DIR_Y:   dir_y = sext19(value);
         CSR_PLANE_X: pln_x = sext19(value);
         CSR_PLANE_Y: pln_y = sext19(value);
         default: ;
      endcase
   endtask

   task automatic set_camera(longint px, longint py, longint dx, longint dy,
                             longint qx, longint qy);
      @(posedge clock);
      write_reg(CSR_POS_X, px);
      write_reg(CSR_POS_Y, py);
      write_reg(CSR_DIR_X, dx & 64'h7FFFF);
      write_reg(CSR_DIR_Y, dy & 64'h7FFFF);
      write_reg(CSR_PLANE_X, qx & 64'h7FFFF);
      write_reg(CSR_PLANE_Y, qy & 64'h7FFFF);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type map_write(int x, int y, int v);
      req_type q;
      q = '0;
      q.mode = MODE_WRITE;
      q.column = 10'($urandom_range(0, 1023));
      q.cell_x = COORD_W'(x);
      q.cell_y = COORD_W'(y);
      q.cell_value = CELL_W'(v);
      return q;
   endfunction

   function automatic req_type cast(int col);
      req_type q;
      q = '0;
      q.mode = MODE_CAST;
      q.column = 10'(col);
      q.cell_x = COORD_W'($urandom_range(0, 63));
      q.cell_y = COORD_W'($urandom_range(0, 63));
      q.cell_value = CELL_W'($urandom_range(0, 255));
      return q;
   endfunction

   // Walls are mostly placed on the border so that most rays end on something.
   task automatic queue_random(int count);
      int k, x, y, v;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) < 4) begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
            case ($urandom_range(0, 3))
               0: x = 0;
               1: x = 63;
               2: y = 0;
               default: if ($urandom_range(0, 1)) y = 63;
            endcase
            case ($urandom_range(0, 9))
               0: v = EMPTY_A;
               1: v = EMPTY_B;
               2, 3: v = $urandom_range(0, 255);
               default: v = $urandom_range(8'h31, 8'h39);
            endcase
            pending_reqs.push_back(map_write(x, y, v));
         end else if ($urandom_range(0, 9) == 0) begin
            pending_reqs.push_back(cast($urandom_range(0, 1023)));
         end else begin
            pending_reqs.push_back(cast($urandom_range(0, SCREEN_WIDTH - 1)));
         end
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || expected_hits.size() > 0 || req_valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_camera();
      set_camera($urandom_range(65536, 63 * 65536 - 1), $urandom_range(65536, 63 * 65536 - 1),
                 longint'($urandom_range(0, 262144)) - 131072,
                 longint'($urandom_range(0, 262144)) - 131072,
                 longint'($urandom_range(0, 262144)) - 131072,
                 longint'($urandom_range(0, 262144)) - 131072);
   endtask

   initial begin
      int p;
      foreach (map_mirror[i]) map_mirror[i] = EMPTY_A;
      cam_x = 2162688; cam_y = 2162688;
      dir_x = -65536; dir_y = 0; pln_x = 0; pln_y = 43253;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_camera(2162688, 2162688, -65536, 0, 0, 43253);

      // Directed: empty map, then walls of several kinds near the camera and in the map corners.
      pending_reqs.push_back(cast(320));
      pending_reqs.push_back(cast(0));
      pending_reqs.push_back(map_write(30, 33, 8'h31));
      pending_reqs.push_back(map_write(29, 33, 8'hFF));
      pending_reqs.push_back(map_write(31, 33, EMPTY_B));
      pending_reqs.push_back(map_write(28, 33, 8'h00));
      pending_reqs.push_back(map_write(63, 63, 8'hFF));
      pending_reqs.push_back(map_write(0, 0, 8'h32));
      pending_reqs.push_back(map_write(63, 0, EMPTY_A));
      pending_reqs.push_back(cast(320));
      pending_reqs.push_back(cast(0));
      pending_reqs.push_back(cast(639));
      pending_reqs.push_back(cast(1023));
      pending_reqs.push_back(cast(319));
      pending_reqs.push_back(map_write(32, 33, 8'h35));
      pending_reqs.push_back(cast(320));
      pending_reqs.push_back(map_write(32, 33, EMPTY_A));
      pending_reqs.push_back(cast(320));
      drain();

      // Extremes of the position registers, then an axis-aligned ray with a zero plane.
      set_camera(0, 0, -131072, -131072, -131072, 131072);
      pending_reqs.push_back(cast(0));
      pending_reqs.push_back(cast(639));
      queue_random(40);
      drain();
      set_camera(22'h3FFFFF, 22'h3FFFFF, 131072, 131072, 131072, -131072);
      queue_random(40);
      drain();
      set_camera(32 * 65536, 5 * 65536 + 100, 0, 131072, 0, 0);
      queue_random(30);
      drain();

      for (p = 0; p < 7; p++) begin
         random_camera();
         queue_random(140);
         drain();
      end

      quiet = 1'b1;
      set_camera(2162688, 2162688, -65536, 0, 0, 43253);
      queue_random(60);
      drain();

      $display("Covered %0d map writes and %0d casts (%0d lost rays) over 12 camera setups.",
               n_writes, n_casts, n_lost);
      $display("%0d result transactions checked, %0d failures.", n_checked, failures);
      if (failures == 0 && expected_hits.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
